@@ rtl/core/rsa_pkg.sv @@
// Package for the running statistics accumulator: widths, function codes,
// sequencer states and the command/status structs of the shared iterative unit.
// No dependencies.
package rsa_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 24;
  localparam int FRAC_W   = 8;

  localparam int SUM_W  = SAMPLE_W + COUNT_W;
  localparam int SQ_W   = 2 * SAMPLE_W + COUNT_W;
  localparam int MEAN_W = SAMPLE_W + FRAC_W;
  localparam int VAR_W  = 2 * MEAN_W;
  localparam int DQ_W   = SUM_W + FRAC_W;
  localparam int NUM_W  = SQ_W + 2 * FRAC_W;
  localparam int REM_W  = ((MEAN_W > COUNT_W) ? MEAN_W : COUNT_W) + 2;
  localparam int STEP_W = $clog2(NUM_W + 1);

  localparam logic [DQ_W-1:0] MEAN_HALF = DQ_W'(1) << (MEAN_W - 1);

  localparam logic [STEP_W-1:0] MEAN_DIV_STEPS = STEP_W'(DQ_W);
  localparam logic [STEP_W-1:0] MSQ_DIV_STEPS  = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0] SQRT_STEPS     = STEP_W'(VAR_W / 2);

  typedef enum logic [1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_ADD_UPD = 2'd1,
    FUNC_UPD     = 2'd2,
    FUNC_CLEAR   = 2'd3
  } rsa_func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACC,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MSQ_GO,
    ST_MSQ_WAIT,
    ST_MUL,
    ST_VAR,
    ST_RMS_GO,
    ST_RMS_WAIT,
    ST_SD_GO,
    ST_SD_WAIT,
    ST_DONE
  } rsa_state_t;

  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [STEP_W-1:0] steps;
  } iter_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

endpackage

@@ rtl/core/rsa_if.sv @@
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on rsa_pkg for field widths.
interface rsa_in_if import rsa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink (input valid, input func, input sample, output ready);
endinterface

interface rsa_out_if import rsa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [COUNT_W-1:0]         count;
  logic signed [SAMPLE_W-1:0] min_value;
  logic signed [SAMPLE_W-1:0] max_value;
  logic signed [MEAN_W-1:0]   mean;
  logic [MEAN_W-1:0]          rms;
  logic [VAR_W-1:0]           variance;
  logic [MEAN_W-1:0]          stddev;
  logic                       stats_valid;
  logic                       saturated;

  modport source (output valid, output count, output min_value, output max_value,
                  output mean, output rms, output variance, output stddev,
                  output stats_valid, output saturated, input ready);
  modport sink (input valid, input count, input min_value, input max_value,
                input mean, input rms, input variance, input stddev,
                input stats_valid, input saturated, output ready);
endinterface

@@ rtl/core/running_stats_accumulator.sv @@
// Top level of the running statistics accumulator: accumulators, sequencer,
// output register. Depends on rsa_pkg, rsa_if and rsa_iter.
//
//   channel   dir   handshake      beat
//   in_chan   in    valid/ready    func, sample
//   out_chan  out   valid/ready    count, min/max, mean, rms, variance,
//                                  stddev, stats_valid, saturated
//
// Add or clear: each beat steps through capture, square, accumulate and load.
// A stats update also runs the one bit-serial divide/root unit:
// 48 steps for the mean, 72 for the mean square, 24 per square root.
// One beat is in work at a time; in_chan.ready is high only when idle.
// A finished result waits in the output register; a stalled out_chan holds it.
// Reset (rst_n low, synchronous) zeroes all accumulators and statistics.
module running_stats_accumulator import rsa_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  rsa_in_if.sink    in_chan,
  rsa_out_if.source out_chan
);

  rsa_state_t state_r;
  rsa_state_t state_nxt;

  logic [1:0]                 func_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [2*SAMPLE_W-1:0]      sq_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]            sumsq_r;
  logic [COUNT_W-1:0]         count_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic signed [MEAN_W-1:0]   mean_r;
  logic [MEAN_W-1:0]          qmag_r;
  logic [VAR_W-1:0]           msq_r;
  logic [VAR_W-1:0]           sqm_r;
  logic [VAR_W-1:0]           var_r;
  logic [MEAN_W-1:0]          rms_r;
  logic [MEAN_W-1:0]          sd_r;
  logic                       upd_r;
  logic                       sat_r;

  logic                       out_valid_r;
  logic [COUNT_W-1:0]         out_count_r;
  logic signed [SAMPLE_W-1:0] out_min_r;
  logic signed [SAMPLE_W-1:0] out_max_r;
  logic signed [MEAN_W-1:0]   out_mean_r;
  logic [MEAN_W-1:0]          out_rms_r;
  logic [VAR_W-1:0]           out_var_r;
  logic [MEAN_W-1:0]          out_sd_r;
  logic                       out_upd_r;
  logic                       out_sat_r;

  iter_cmd_t        iter_cmd;
  iter_sts_t        iter_sts;
  logic [NUM_W-1:0] iter_num;
  logic [NUM_W-1:0] iter_quo;

  logic                       in_ready;
  logic                       in_acc;
  logic                       out_load;
  logic                       is_add;
  logic                       is_upd;
  logic                       full;
  logic                       add_ok;
  logic                       upd_go;
  logic signed [2*SAMPLE_W-1:0] sq_prod;
  logic                       sum_neg;
  logic [SUM_W-1:0]           sum_mag;
  logic [DQ_W-1:0]            q_raw;
  logic [DQ_W-1:0]            q_clamp;
  logic [MEAN_W-1:0]          q_cut;

  rsa_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (iter_cmd),
    .num     (iter_num),
    .divisor (count_r),
    .sts     (iter_sts),
    .quo     (iter_quo)
  );

  always_comb begin
    is_add  = (func_r == FUNC_ADD) || (func_r == FUNC_ADD_UPD);
    is_upd  = (func_r == FUNC_ADD_UPD) || (func_r == FUNC_UPD);
    full    = (count_r == '1);
    add_ok  = is_add && !full;
    upd_go  = is_upd && (add_ok || (count_r != '0));
    sq_prod = sample_r * sample_r;
    sum_neg = sum_r[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    q_raw   = iter_quo[DQ_W-1:0];
    if (sum_neg) begin
      q_clamp = (q_raw > MEAN_HALF) ? MEAN_HALF : q_raw;
    end else begin
      q_clamp = (q_raw > MEAN_HALF - DQ_W'(1)) ? MEAN_HALF - DQ_W'(1) : q_raw;
    end
    q_cut = q_clamp[MEAN_W-1:0];
  end

  assign in_acc   = in_chan.valid && in_ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_acc) state_nxt = ST_SQUARE;
      ST_SQUARE:    state_nxt = ST_ACC;
      ST_ACC:       state_nxt = upd_go ? ST_MEAN_GO : ST_DONE;
      ST_MEAN_GO:   state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (iter_sts.done) state_nxt = ST_MSQ_GO;
      ST_MSQ_GO:    state_nxt = ST_MSQ_WAIT;
      ST_MSQ_WAIT:  if (iter_sts.done) state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_VAR;
      ST_VAR:       state_nxt = ST_RMS_GO;
      ST_RMS_GO:    state_nxt = ST_RMS_WAIT;
      ST_RMS_WAIT:  if (iter_sts.done) state_nxt = ST_SD_GO;
      ST_SD_GO:     state_nxt = ST_SD_WAIT;
      ST_SD_WAIT:   if (iter_sts.done) state_nxt = ST_DONE;
      ST_DONE:      if (out_load) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    iter_cmd = '0;
    iter_num = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_MEAN_GO: begin
        iter_cmd.start = 1'b1;
        iter_cmd.steps = MEAN_DIV_STEPS;
        iter_num       = {sum_mag, FRAC_W'(0), (NUM_W - DQ_W)'(0)};
      end
      ST_MSQ_GO: begin
        iter_cmd.start = 1'b1;
        iter_cmd.steps = MSQ_DIV_STEPS;
        iter_num       = {sumsq_r, (2 * FRAC_W)'(0)};
      end
      ST_RMS_GO: begin
        iter_cmd.start     = 1'b1;
        iter_cmd.sqrt_mode = 1'b1;
        iter_cmd.steps     = SQRT_STEPS;
        iter_num           = {msq_r, (NUM_W - VAR_W)'(0)};
      end
      ST_SD_GO: begin
        iter_cmd.start     = 1'b1;
        iter_cmd.sqrt_mode = 1'b1;
        iter_cmd.steps     = SQRT_STEPS;
        iter_num           = {var_r, (NUM_W - VAR_W)'(0)};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      count_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      mean_r      <= '0;
      var_r       <= '0;
      rms_r       <= '0;
      sd_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_ACC: begin
          if (func_r == FUNC_CLEAR) begin
            sum_r   <= '0;
            sumsq_r <= '0;
            count_r <= '0;
            min_r   <= '0;
            max_r   <= '0;
            mean_r  <= '0;
            var_r   <= '0;
            rms_r   <= '0;
            sd_r    <= '0;
          end else if (add_ok) begin
            if ((count_r == '0) || (sample_r < min_r)) min_r <= sample_r;
            if ((count_r == '0) || (sample_r > max_r)) max_r <= sample_r;
            sum_r   <= sum_r + SUM_W'(sample_r);
            sumsq_r <= sumsq_r + SQ_W'(sq_r);
            count_r <= count_r + COUNT_W'(1);
          end
        end
        ST_MEAN_WAIT: begin
          if (iter_sts.done) begin
            mean_r <= sum_neg ? MEAN_W'(-q_cut) : q_cut;
          end
        end
        ST_VAR: begin
          var_r <= (msq_r > sqm_r) ? msq_r - sqm_r : '0;
        end
        ST_RMS_WAIT: begin
          if (iter_sts.done) rms_r <= iter_quo[MEAN_W-1:0];
        end
        ST_SD_WAIT: begin
          if (iter_sts.done) sd_r <= iter_quo[MEAN_W-1:0];
        end
        default: begin
          sum_r <= sum_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_chan.func;
      sample_r <= in_chan.sample;
    end
    if (state_r == ST_SQUARE) sq_r <= sq_prod;
    if (state_r == ST_ACC) begin
      upd_r <= upd_go;
      sat_r <= is_add && full;
    end
    if ((state_r == ST_MEAN_WAIT) && iter_sts.done) qmag_r <= q_cut;
    if ((state_r == ST_MSQ_WAIT) && iter_sts.done) msq_r <= iter_quo[VAR_W-1:0];
    if (state_r == ST_MUL) sqm_r <= qmag_r * qmag_r;
    if (out_load) begin
      out_count_r <= count_r;
      out_min_r   <= min_r;
      out_max_r   <= max_r;
      out_mean_r  <= mean_r;
      out_rms_r   <= rms_r;
      out_var_r   <= var_r;
      out_sd_r    <= sd_r;
      out_upd_r   <= upd_r;
      out_sat_r   <= sat_r;
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.count       = out_count_r;
  assign out_chan.min_value   = out_min_r;
  assign out_chan.max_value   = out_max_r;
  assign out_chan.mean        = out_mean_r;
  assign out_chan.rms         = out_rms_r;
  assign out_chan.variance    = out_var_r;
  assign out_chan.stddev      = out_sd_r;
  assign out_chan.stats_valid = out_upd_r;
  assign out_chan.saturated   = out_sat_r;

  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !iter_sts.busy)
    else $error("shared unit busy while sequencer idle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    iter_sts.done |-> ((state_r == ST_MEAN_WAIT) || (state_r == ST_MSQ_WAIT) ||
                       (state_r == ST_RMS_WAIT) || (state_r == ST_SD_WAIT)))
    else $error("shared unit finished outside a wait state");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (min_r <= max_r))
    else $error("minimum above maximum");

  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_count_r == '1))
    else $error("saturated beat with count not full");

endmodule

@@ rtl/core/rsa_iter.sv @@
// Shared bit-serial unit: restoring divide (one quotient bit per step) or
// digit-by-digit square root (one root bit per step) on one compare/subtract.
// Depends on rsa_pkg.
module rsa_iter import rsa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  iter_cmd_t          cmd,
  input  logic [NUM_W-1:0]   num,
  input  logic [COUNT_W-1:0] divisor,
  output iter_sts_t          sts,
  output logic [NUM_W-1:0]   quo
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic              mode_r;
  logic [NUM_W-1:0]  num_r;
  logic [REM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [COUNT_W-1:0] div_r;

  logic [REM_W-1:0] part;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic             ge;
  logic [REM_W-1:0] rem_nxt;

  always_comb begin
    if (mode_r) begin
      part  = {rem_r[REM_W-3:0], num_r[NUM_W-1 -: 2]};
      trial = REM_W'({quo_r[MEAN_W-1:0], 2'b01});
    end else begin
      part  = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
      trial = REM_W'(div_r);
    end
    ge      = (part >= trial);
    diff    = part - trial;
    rem_nxt = ge ? diff : part;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= cmd.sqrt_mode;
      num_r  <= num;
      rem_r  <= '0;
      quo_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      num_r <= mode_r ? {num_r[NUM_W-3:0], 2'b00} : {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

@@ verif/rsa_stats_checker.sv @@
// Checker for the running statistics accumulator: watches both channels, predicts
// each result beat from the accepted input beats and compares field by field.
// Depends on rsa_pkg and rsa_if.
`timescale 1ns / 1ps

module rsa_stats_checker import rsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rsa_in_if    in_mon,
  rsa_out_if   out_mon,
  output int   stat_errors,
  output int   stat_pending
);

  typedef struct {
    logic [COUNT_W-1:0]         count;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic signed [MEAN_W-1:0]   mean;
    logic [MEAN_W-1:0]          rms;
    logic [VAR_W-1:0]           variance;
    logic [MEAN_W-1:0]          stddev;
    logic                       stats_valid;
    logic                       saturated;
  } stat_beat_t;

  logic signed [SUM_W-1:0]    run_sum;
  logic [SQ_W-1:0]            run_sumsq;
  logic [COUNT_W-1:0]         run_count;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic signed [MEAN_W-1:0]   st_mean;
  logic [VAR_W-1:0]           st_var;
  logic [MEAN_W-1:0]          st_rms;
  logic [MEAN_W-1:0]          st_sd;

  stat_beat_t expected_stats[$];
  int         err_cnt = 0;

  function automatic void clear_stats();
    run_sum   = '0;
    run_sumsq = '0;
    run_count = '0;
    run_min   = '0;
    run_max   = '0;
    st_mean   = '0;
    st_var    = '0;
    st_rms    = '0;
    st_sd     = '0;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bit_v;
    root  = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= root + bit_v) begin
        x    = x - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] clamp_to(logic [63:0] v, int w);
    logic [63:0] lim;
    lim = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    return (v > lim) ? lim : v;
  endfunction

  function automatic void refresh_stats();
    logic signed [63:0] s64;
    logic [63:0]        mag;
    logic [63:0]        q;
    logic [63:0]        half;
    logic [63:0]        msq;
    logic [63:0]        msq2;
    logic [63:0]        vr;
    logic [127:0]       num;
    s64  = run_sum;
    mag  = (s64 < 0) ? 64'(-s64) : 64'(s64);
    num  = {64'd0, mag} << FRAC_W;
    q    = 64'(num / run_count);
    half = 64'd1 << (MEAN_W - 1);
    if (s64 < 0) begin
      if (q > half) q = half;
      st_mean = MEAN_W'(64'd0 - q);
    end else begin
      if (q > half - 64'd1) q = half - 64'd1;
      st_mean = MEAN_W'(q);
    end
    num    = {72'd0, run_sumsq} << (2 * FRAC_W);
    msq    = 64'(num / run_count);
    msq2   = q * q;
    st_rms = MEAN_W'(clamp_to(int_sqrt(msq), MEAN_W));
    vr     = (msq > msq2) ? msq - msq2 : 64'd0;
    st_var = VAR_W'(clamp_to(vr, VAR_W));
    st_sd  = MEAN_W'(clamp_to(int_sqrt(64'(st_var)), MEAN_W));
  endfunction

  function automatic stat_beat_t predict_stats(rsa_func_t f, logic signed [SAMPLE_W-1:0] x);
    stat_beat_t          r;
    logic [SAMPLE_W:0]   ax;
    logic                drop;
    logic                upd;
    drop = 1'b0;
    upd  = 1'b0;
    if (f == FUNC_CLEAR) begin
      clear_stats();
    end else if (f == FUNC_ADD || f == FUNC_ADD_UPD) begin
      if (run_count == '1) begin
        drop = 1'b1;
      end else begin
        ax = (x < 0) ? (SAMPLE_W + 1)'(-$signed({x[SAMPLE_W-1], x})) : (SAMPLE_W + 1)'(x);
        if (run_count == 0 || x < run_min) run_min = x;
        if (run_count == 0 || x > run_max) run_max = x;
        run_sum   = run_sum + x;
        run_sumsq = run_sumsq + SQ_W'(ax) * SQ_W'(ax);
        run_count = run_count + 1'b1;
      end
    end
    if ((f == FUNC_ADD_UPD || f == FUNC_UPD) && run_count != 0) begin
      refresh_stats();
      upd = 1'b1;
    end
    r.count       = run_count;
    r.min_value   = run_min;
    r.max_value   = run_max;
    r.mean        = st_mean;
    r.rms         = st_rms;
    r.variance    = st_var;
    r.stddev      = st_sd;
    r.stats_valid = upd;
    r.saturated   = drop;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    stat_beat_t want;
    stat_beat_t got;
    if (!rst_n) begin
      clear_stats();
      expected_stats.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.count       = out_mon.count;
        got.min_value   = out_mon.min_value;
        got.max_value   = out_mon.max_value;
        got.mean        = out_mon.mean;
        got.rms         = out_mon.rms;
        got.variance    = out_mon.variance;
        got.stddev      = out_mon.stddev;
        got.stats_valid = out_mon.stats_valid;
        got.saturated   = out_mon.saturated;
        if (expected_stats.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat expected none actual count %0h", $time, got.count);
        end else begin
          want = expected_stats.pop_front();
          check_field("count", 64'(want.count), 64'(got.count));
          check_field("min_value", 64'(want.min_value), 64'(got.min_value));
          check_field("max_value", 64'(want.max_value), 64'(got.max_value));
          check_field("mean", 64'(want.mean), 64'(got.mean));
          check_field("rms", 64'(want.rms), 64'(got.rms));
          check_field("variance", 64'(want.variance), 64'(got.variance));
          check_field("stddev", 64'(want.stddev), 64'(got.stddev));
          check_field("stats_valid", 64'(want.stats_valid), 64'(got.stats_valid));
          check_field("saturated", 64'(want.saturated), 64'(got.saturated));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_stats.push_back(predict_stats(rsa_func_t'(in_mon.func), in_mon.sample));
    end
    stat_pending <= expected_stats.size();
    stat_errors  <= err_cnt;
  end

endmodule

@@ verif/tb_running_stats_accumulator.sv @@
// Testbench top for running_stats_accumulator: clock, reset, stimulus beats and
// random stalls on both channels; the verdict comes from rsa_stats_checker.
// Depends on rsa_pkg, rsa_if, the block and the checker.
`timescale 1ns / 1ps

module tb_running_stats_accumulator;
  import rsa_pkg::*;

  localparam int RANDOM_BEATS = 400;
  localparam int CALM_FROM    = 340;
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst_n;
  int   beats_sent = 0;
  int   cycle_cnt = 0;
  int   stat_errors;
  int   stat_pending;
  logic calm = 1'b0;

  rsa_in_if  in_bus();
  rsa_out_if out_bus();

  running_stats_accumulator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  rsa_stats_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .stat_errors  (stat_errors),
    .stat_pending (stat_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_beat(rsa_func_t f, logic signed [SAMPLE_W-1:0] s);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.func   <= f;
    in_bus.sample <= s;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    beats_sent++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] next_sample(int style,
                                                             logic signed [SAMPLE_W-1:0] base);
    logic signed [SAMPLE_W-1:0] v;
    case (style)
      0: v = SAMPLE_W'($urandom);
      1: v = SAMPLE_W'($urandom_range(0, 31)) - 16'sd16;
      2: v = base;
      3: v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: v = base + (SAMPLE_W'($urandom_range(0, 255)) - 16'sd128);
    endcase
    return v;
  endfunction

  task automatic run_burst();
    int                         n;
    int                         style;
    logic signed [SAMPLE_W-1:0] base;
    rsa_func_t                  f;
    n     = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    style = $urandom_range(0, 4);
    base  = SAMPLE_W'($urandom);
    if ($urandom_range(0, 9) == 0) send_beat(FUNC_CLEAR, SAMPLE_W'($urandom));
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(0, 5) == 0) ? FUNC_ADD_UPD : FUNC_ADD;
      send_beat(f, next_sample(style, base));
    end
    case ($urandom_range(0, 3))
      0: send_beat(FUNC_UPD, SAMPLE_W'($urandom));
      1: send_beat(FUNC_ADD_UPD, next_sample(style, base));
      2: send_beat(rsa_func_t'($urandom_range(0, 3)), SAMPLE_W'($urandom));
      default: ;
    endcase
  endtask

  initial begin
    int start_cnt;
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.func   <= FUNC_ADD;
    in_bus.sample <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(FUNC_UPD, 16'sh0000);
    send_beat(FUNC_CLEAR, 16'sh0000);
    send_beat(FUNC_ADD, 16'sh8000);
    send_beat(FUNC_ADD, 16'sh7FFF);
    send_beat(FUNC_UPD, 16'sh0000);
    send_beat(FUNC_ADD, 16'sh0000);
    send_beat(FUNC_ADD_UPD, -16'sd1);
    send_beat(FUNC_CLEAR, 16'sh0000);
    send_beat(FUNC_UPD, 16'sh7FFF);
    send_beat(FUNC_ADD_UPD, 16'sd1);
    send_beat(FUNC_ADD_UPD, 16'sd1);
    send_beat(FUNC_CLEAR, 16'shFFFF);
    send_beat(FUNC_ADD, 16'sh8000);
    send_beat(FUNC_ADD, 16'sh8000);
    send_beat(FUNC_ADD_UPD, 16'sh8000);
    send_beat(FUNC_CLEAR, 16'sh0000);
    send_beat(FUNC_ADD_UPD, 16'sh7FFF);
    send_beat(FUNC_ADD_UPD, 16'sh7FFF);
    send_beat(FUNC_ADD, 16'sh5555);
    send_beat(FUNC_ADD_UPD, 16'shAAAA);
    send_beat(FUNC_CLEAR, 16'shFFFF);
    send_beat(FUNC_ADD_UPD, 16'sh8000);
    send_beat(FUNC_ADD_UPD, 16'sh7FFF);

    start_cnt = beats_sent;
    while (beats_sent - start_cnt < RANDOM_BEATS) begin
      if (beats_sent - start_cnt >= CALM_FROM) calm = 1'b1;
      run_burst();
    end
    in_bus.valid <= 1'b0;

    @(posedge clk);
    while (stat_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stat_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rsa_pkg.sv
rtl/core/rsa_if.sv
rtl/core/rsa_iter.sv
rtl/core/running_stats_accumulator.sv
verif/rsa_stats_checker.sv
verif/tb_running_stats_accumulator.sv
